/* src/mau_pkg.sv */
`default_nettype none
package mau_pkg;
	localparam int unsigned VALUE_WIDTH_DEFAULT = 62;
	localparam logic [61:0] RESET_MODULUS = 62'd1000000007;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		K_REDUCE = 3'd0,
		K_ADD    = 3'd1,
		K_SUB    = 3'd2,
		K_MUL    = 3'd3,
		K_DIV    = 3'd4,
		K_POW    = 3'd5,
		K_NEG    = 3'd6,
		K_INV    = 3'd7
	} kind_t;
endpackage
`default_nettype wire

/* src/mau_if.sv */
`default_nettype none
interface mau_req_if #(parameter int unsigned W = 62);
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [W-1:0]       operand_a;
	logic [W-1:0]       operand_b;
	logic signed [63:0] exponent;
	logic signed [63:0] raw_value;
	modport source (output valid, kind, operand_a, operand_b, exponent, raw_value,
		input ready);
	modport sink (input valid, kind, operand_a, operand_b, exponent, raw_value,
		output ready);
endinterface

interface mau_rsp_if #(parameter int unsigned W = 62);
	logic         valid;
	logic         ready;
	logic [W-1:0] result;
	logic         a_equals_b;
	logic         a_less_b;
	modport source (output valid, result, a_equals_b, a_less_b, input ready);
	modport sink (input valid, result, a_equals_b, a_less_b, output ready);
endinterface
`default_nettype wire

/* src/mau_front.sv */
`default_nettype none
// Front: registers requests into a small queue. Reduction is done in the back.
module mau_front import mau_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	mau_req_if.sink                     req,
	output logic                        q_valid,
	input  wire logic                   q_pop,
	output logic [2:0]                  q_kind,
	output logic [VALUE_WIDTH-1:0]      q_a,
	output logic [VALUE_WIDTH-1:0]      q_b,
	output logic [63:0]                 q_e,
	output logic [63:0]                 q_raw
);
	logic [2:0]             kind_q [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] a_q    [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] b_q    [QUEUE_DEPTH];
	logic [63:0]            e_q    [QUEUE_DEPTH];
	logic [63:0]            raw_q  [QUEUE_DEPTH];
	logic                   wp_q, rp_q;
	logic [1:0]             cnt_q;
	logic                   push;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_kind    = kind_q[rp_q];
	assign q_a       = a_q[rp_q];
	assign q_b       = b_q[rp_q];
	assign q_e       = e_q[rp_q];
	assign q_raw     = raw_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wp_q] <= req.kind;
			a_q[wp_q]    <= req.operand_a;
			b_q[wp_q]    <= req.operand_b;
			e_q[wp_q]    <= req.exponent;
			raw_q[wp_q]  <= req.raw_value;
		end
	end
endmodule
`default_nettype wire

/* src/mau_back.sv */
`default_nettype none
// Back: a sequencer around one shift-add modular multiplier (one bit per cycle)
// and one restoring remainder unit (one bit per cycle).
module mau_back import mau_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [VALUE_WIDTH-1:0] modulus,
	input  wire logic                   q_valid,
	output logic                        q_pop,
	input  wire logic [2:0]             q_kind,
	input  wire logic [VALUE_WIDTH-1:0] q_a,
	input  wire logic [VALUE_WIDTH-1:0] q_b,
	input  wire logic [63:0]            q_e,
	input  wire logic [63:0]            q_raw,
	mau_rsp_if.source                   rsp
);
	localparam int unsigned W = VALUE_WIDTH;
	localparam logic [6:0] BITS_M1 = 7'(W - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_REM_A, S_REM_B, S_REM_RAW, S_DISPATCH, S_MUL,
		S_POW_STEP, S_AFTER_INV, S_OUT
	} state_t;

	state_t         state_q;
	kind_t          kind_q;
	logic [W-1:0]   m_q, a_q, b_q, r_q;
	logic [63:0]    e_q, raw_q;
	// remainder unit
	logic [63:0]    dnd_q;
	logic [W:0]     rem_q;
	logic [6:0]     cnt_q;
	// multiplier
	logic [W-1:0]   mx_q, my_q, acc_q;
	// power
	logic [W-1:0]   pb_q, pr_q;
	logic [63:0]    pe_q;
	logic           pphase_q; // 0: multiply result, 1: square base
	logic           pinv_q;   // power of the inverse still to follow (divide: set for the final multiply by a)
	logic           rneg_q;

	logic [W-1:0]   m_eff;
	logic [W+1:0]   rem_sh;
	logic [W:0]     dbl, dbl_add;
	logic [W-1:0]   dbl_r, dbl_rr;
	logic [W-1:0]   sub_val;
	logic [W:0]     add_val;

	assign m_eff = (modulus < W'(2)) ? W'(2) : modulus;

	always_comb begin
		rem_sh = {rem_q, dnd_q[63]};
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : dbl[W-1:0];
		dbl_add = {1'b0, dbl_r} + {1'b0, mx_q};
		dbl_rr = (dbl_add >= {1'b0, m_q}) ? W'(dbl_add - {1'b0, m_q}) : dbl_add[W-1:0];
		add_val = {1'b0, a_q} + {1'b0, b_q};
		sub_val = (a_q >= b_q) ? (a_q - b_q) : W'({1'b0, a_q} + {1'b0, m_q} - {1'b0, b_q});
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp.valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (q_valid) begin
					kind_q <= kind_t'(q_kind);
					m_q    <= m_eff;
					// Operands are left-aligned so the remainder unit starts at their top bit.
					dnd_q  <= {q_a, {(64 - W){1'b0}}};
					b_q    <= q_b;
					e_q    <= q_e;
					raw_q  <= q_raw;
					rem_q  <= '0;
					cnt_q  <= BITS_M1;
					state_q <= S_REM_A;
				end
				S_REM_A, S_REM_B, S_REM_RAW: begin
					logic [W+1:0] t;
					t = rem_sh;
					if (t >= {2'b0, m_q}) t = t - {2'b0, m_q};
					if (cnt_q != 7'd0) begin
						rem_q <= t[W:0];
						dnd_q <= {dnd_q[62:0], 1'b0};
						cnt_q <= cnt_q - 7'd1;
					end else begin
						rem_q <= '0;
						if (state_q == S_REM_A) begin
							a_q <= t[W-1:0];
							dnd_q <= {b_q, {(64 - W){1'b0}}};
							cnt_q <= BITS_M1;
							state_q <= S_REM_B;
						end else if (state_q == S_REM_B) begin
							b_q <= t[W-1:0];
							rneg_q <= raw_q[63];
							dnd_q <= raw_q[63] ? (64'd0 - raw_q) : raw_q;
							cnt_q <= 7'd63;
							state_q <= (kind_q == K_REDUCE) ? S_REM_RAW : S_DISPATCH;
						end else begin
							r_q <= (rneg_q && t[W-1:0] != '0) ? (m_q - t[W-1:0]) : t[W-1:0];
							state_q <= S_OUT;
						end
					end
				end
				S_DISPATCH: begin
					pphase_q <= 1'b0;
					pinv_q   <= 1'b0;
					case (kind_q)
						K_ADD: begin
							r_q <= (add_val >= {1'b0, m_q}) ? W'(add_val - {1'b0, m_q})
								: add_val[W-1:0];
							state_q <= S_OUT;
						end
						K_SUB: begin
							r_q <= sub_val;
							state_q <= S_OUT;
						end
						K_NEG: begin
							r_q <= (a_q == '0) ? '0 : (m_q - a_q);
							state_q <= S_OUT;
						end
						K_MUL: begin
							mx_q <= a_q; my_q <= b_q; acc_q <= '0;
							cnt_q <= BITS_M1;
							state_q <= S_MUL;
						end
						K_DIV: begin
							// inverse of b first, then multiply by a
							pb_q <= b_q; pe_q <= 64'(m_q - W'(2));
							pr_q <= (m_q == W'(1)) ? '0 : W'(1);
							state_q <= S_POW_STEP;
						end
						K_INV: begin
							pb_q <= a_q; pe_q <= 64'(m_q - W'(2)); pr_q <= W'(1);
							state_q <= S_POW_STEP;
						end
						K_POW: begin
							pr_q <= W'(1);
							if (e_q[63]) begin
								pb_q <= a_q; pe_q <= 64'(m_q - W'(2)); pinv_q <= 1'b1;
							end else begin
								pb_q <= a_q; pe_q <= e_q;
							end
							state_q <= S_POW_STEP;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_POW_STEP: begin
					if (pe_q == 64'd0) begin
						state_q <= S_AFTER_INV;
					end else if (!pphase_q && pe_q[0]) begin
						mx_q <= pr_q; my_q <= pb_q; acc_q <= '0;
						cnt_q <= BITS_M1; state_q <= S_MUL;
					end else begin
						mx_q <= pb_q; my_q <= pb_q; acc_q <= '0;
						pphase_q <= 1'b1;
						cnt_q <= BITS_M1; state_q <= S_MUL;
					end
				end
				S_MUL: begin
					acc_q <= my_q[W-1] ? dbl_rr : dbl_r;
					my_q  <= {my_q[W-2:0], 1'b0};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						if (kind_q == K_MUL || (kind_q == K_DIV && pinv_q)) begin
							r_q <= my_q[W-1] ? dbl_rr : dbl_r;
							state_q <= S_OUT;
						end else if (!pphase_q && pe_q[0]) begin
							pr_q <= my_q[W-1] ? dbl_rr : dbl_r;
							pphase_q <= 1'b1;
							state_q <= S_POW_STEP;
						end else begin
							pb_q <= my_q[W-1] ? dbl_rr : dbl_r;
							pe_q <= {1'b0, pe_q[63:1]};
							pphase_q <= 1'b0;
							state_q <= S_POW_STEP;
						end
					end
				end
				S_AFTER_INV: begin
					if (kind_q == K_DIV) begin
						mx_q <= a_q; my_q <= pr_q; acc_q <= '0;
						pinv_q <= 1'b1;
						cnt_q <= BITS_M1; state_q <= S_MUL;
					end else if (kind_q == K_POW && pinv_q) begin
						pb_q <= pr_q; pe_q <= 64'd0 - e_q; pr_q <= W'(1);
						pinv_q <= 1'b0; pphase_q <= 1'b0;
						state_q <= S_POW_STEP;
					end else begin
						r_q <= (m_q == W'(1)) ? '0 : pr_q;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rsp.valid || rsp.ready) begin
						rsp.valid      <= 1'b1;
						rsp.result     <= r_q;
						rsp.a_equals_b <= (a_q == b_q);
						rsp.a_less_b   <= (a_q < b_q);
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (rsp.valid && rsp.ready && state_q != S_OUT) rsp.valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* src/modular_arithmetic_unit_top.sv */
`default_nettype none
// Modular arithmetic unit over a programmable modulus.
// Requests arrive on req (valid/ready); each gives exactly one response on rsp,
// in order. A two-entry queue takes requests while the back end is busy.
// The modulus is written through cfg_we/cfg_data; the user must write it only
// while the unit is idle, which the block itself does not enforce. Values
// below 2 act as 2. Reset sets it to 1000000007. Both operands are reduced
// by a one-bit-per-cycle remainder unit; a reduce request also reduces its
// raw value there. Add, subtract and negate then finish without the
// multiplier; multiply runs on a one-bit-per-cycle shift-add multiplier.
// Power, divide and inverse run square-and-multiply on the same multiplier,
// up to roughly 250 multiplications for a negative exponent. The back end
// handles one request at a time.
// The response is held in an output register; while the receiver stalls it
// stays valid, and the back end waits in its output state before taking the
// next queued request. Reset clears queue, sequencer and response valid.
module modular_arithmetic_unit_top import mau_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [VALUE_WIDTH-1:0] cfg_data,
	mau_req_if.sink                     req,
	mau_rsp_if.source                   rsp
);
	logic [VALUE_WIDTH-1:0] modulus_q;
	logic                   q_valid, q_pop;
	logic [2:0]             q_kind;
	logic [VALUE_WIDTH-1:0] q_a, q_b;
	logic [63:0]            q_e, q_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) modulus_q <= VALUE_WIDTH'(RESET_MODULUS);
		else if (cfg_we) modulus_q <= cfg_data;
	end

	mau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk, .arst_n, .req, .q_valid, .q_pop, .q_kind, .q_a, .q_b, .q_e, .q_raw
	);

	mau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk, .arst_n, .modulus(modulus_q), .q_valid, .q_pop, .q_kind, .q_a, .q_b,
		.q_e, .q_raw, .rsp
	);
endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import mau_pkg::*;

	typedef struct {
		kind_t       kind;
		bit [61:0]   operand_a;
		bit [61:0]   operand_b;
		bit [63:0]   exponent;
		bit [63:0]   raw_value;
	} mod_request_t;

	typedef struct {
		bit [61:0] result;
		bit        a_equals_b;
		bit        a_less_b;
	} mod_answer_t;

	localparam bit [61:0] VALUE_MAX   = {62{1'b1}};
	localparam bit [61:0] BIG_PRIME   = 62'd4611686018427387847;
	localparam bit [63:0] EXP_MOST_NEG = 64'h8000_0000_0000_0000;
	localparam bit [63:0] EXP_MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int        HOLD_CYCLES = 40000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [61:0] cfg_data;

	mau_req_if #(62) req_ch ();
	mau_rsp_if #(62) rsp_ch ();

	modular_arithmetic_unit_top #(.VALUE_WIDTH(62)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	mod_request_t pending_requests[$];
	mod_answer_t  expected_answers[$];
	bit [61:0]    modulus_shadow;
	int           error_count;
	bit           calm;
	bit           hold_go;
	bit           req_fire;
	int           send_gap;
	int           stall_left;
	int           hold_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Predictor of the unit, on 64-bit unsigned values.
	function automatic bit [63:0] mod_add(bit [63:0] x, bit [63:0] y, bit [63:0] m);
		bit [63:0] s;
		s = x + y;
		return (s >= m) ? s - m : s;
	endfunction

	function automatic bit [63:0] mod_sub(bit [63:0] x, bit [63:0] y, bit [63:0] m);
		return (x >= y) ? x - y : x + (m - y);
	endfunction

	function automatic bit [63:0] mod_mul(bit [63:0] x, bit [63:0] y, bit [63:0] m);
		bit [63:0] r;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = mod_add(r, r, m);
			if (y[i])
				r = mod_add(r, x, m);
		end
		return r;
	endfunction

	function automatic bit [63:0] mod_pow(bit [63:0] base, bit [63:0] e, bit [63:0] m);
		bit [63:0] r;
		bit [63:0] b;
		r = 64'd1 % m;
		b = base;
		while (e != 0) begin
			if (e[0])
				r = mod_mul(r, b, m);
			b = mod_mul(b, b, m);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic bit [63:0] reduce_raw(bit [63:0] raw, bit [63:0] m);
		bit [63:0] r;
		if (!raw[63])
			return raw % m;
		r = (64'd0 - raw) % m;
		return (r == 0) ? 64'd0 : m - r;
	endfunction

	function automatic mod_answer_t predict_answer(mod_request_t q, bit [61:0] modulus);
		bit [63:0] m;
		bit [63:0] a;
		bit [63:0] b;
		bit [63:0] r;
		mod_answer_t ans;
		m = (modulus < 2) ? 64'd2 : {2'b00, modulus};
		a = {2'b00, q.operand_a} % m;
		b = {2'b00, q.operand_b} % m;
		case (q.kind)
			K_REDUCE: r = reduce_raw(q.raw_value, m);
			K_ADD:    r = mod_add(a, b, m);
			K_SUB:    r = mod_sub(a, b, m);
			K_MUL:    r = mod_mul(a, b, m);
			K_DIV:    r = mod_mul(a, mod_pow(b, m - 2, m), m);
			K_POW: begin
				if (q.exponent[63])
					r = mod_pow(mod_pow(a, m - 2, m), 64'd0 - q.exponent, m);
				else
					r = mod_pow(a, q.exponent, m);
			end
			K_NEG:    r = mod_sub(0, a, m);
			default:  r = mod_pow(a, m - 2, m);
		endcase
		ans.result = r[61:0];
		ans.a_equals_b = (a == b);
		ans.a_less_b = (a < b);
		return ans;
	endfunction

	function automatic bit [61:0] pick_operand(bit [61:0] modulus);
		bit [63:0] full;
		full = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return 62'd0;
			1: return (modulus < 2) ? 62'd1 : modulus - 62'd1;
			2: return VALUE_MAX;
			3: return full[61:0];
			4: return 62'($urandom_range(0, 1000));
			default: return (modulus < 2) ? full[61:0] : full[61:0] % modulus;
		endcase
	endfunction

	function automatic bit [63:0] pick_signed64();
		case ($urandom_range(0, 5))
			0: return 64'($urandom_range(0, 50));
			1: return 64'd0 - 64'($urandom_range(1, 50));
			2: return EXP_MOST_NEG;
			3: return EXP_MOST_POS;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic mod_request_t random_request(bit [61:0] modulus);
		mod_request_t q;
		q.kind = kind_t'($urandom_range(0, 7));
		q.operand_a = pick_operand(modulus);
		q.operand_b = ($urandom_range(0, 5) == 0) ? q.operand_a : pick_operand(modulus);
		q.exponent = pick_signed64();
		q.raw_value = pick_signed64();
		return q;
	endfunction

	function automatic mod_request_t make_request(kind_t k, bit [61:0] a, bit [61:0] b,
			bit [63:0] e, bit [63:0] raw);
		mod_request_t q;
		q.kind = k;
		q.operand_a = a;
		q.operand_b = b;
		q.exponent = e;
		q.raw_value = raw;
		return q;
	endfunction

	// Request driver: holds an offered request until it is taken.
	always @(negedge clk) begin
		mod_request_t q;
		if (arst_n && !(req_ch.valid && !req_fire)) begin
			if (!calm && send_gap == 0 && $urandom_range(0, 7) == 0)
				send_gap = $urandom_range(1, 18);
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				q = pending_requests.pop_front();
				req_ch.kind <= q.kind;
				req_ch.operand_a <= q.operand_a;
				req_ch.operand_b <= q.operand_b;
				req_ch.exponent <= q.exponent;
				req_ch.raw_value <= q.raw_value;
				req_ch.valid <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response receiver: random stalls, and one long hold-off on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 18);
				if (stall_left > 0) begin
					stall_left--;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Predict on acceptance, check on response.
	always @(posedge clk) begin
		mod_request_t q;
		mod_answer_t want;
		req_fire <= req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			q.kind = kind_t'(req_ch.kind);
			q.operand_a = req_ch.operand_a;
			q.operand_b = req_ch.operand_b;
			q.exponent = req_ch.exponent;
			q.raw_value = req_ch.raw_value;
			expected_answers.push_back(predict_answer(q, modulus_shadow));
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_answers.size() == 0) begin
				$error("unexpected response, result %0d", rsp_ch.result);
				error_count++;
			end else begin
				want = expected_answers.pop_front();
				if (rsp_ch.result !== want.result) begin
					$error("result: expected %0d, actual %0d", want.result, rsp_ch.result);
					error_count++;
				end
				if (rsp_ch.a_equals_b !== want.a_equals_b) begin
					$error("a_equals_b: expected %0d, actual %0d", want.a_equals_b,
						rsp_ch.a_equals_b);
					error_count++;
				end
				if (rsp_ch.a_less_b !== want.a_less_b) begin
					$error("a_less_b: expected %0d, actual %0d", want.a_less_b,
						rsp_ch.a_less_b);
					error_count++;
				end
			end
		end
	end

	task automatic drain();
		wait (pending_requests.size() == 0 && !req_ch.valid && expected_answers.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_modulus(bit [61:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		modulus_shadow = value;
	endtask

	task automatic add_random(int count);
		for (int i = 0; i < count; i++)
			pending_requests.push_back(random_request(modulus_shadow));
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.kind = K_REDUCE;
		req_ch.operand_a = '0;
		req_ch.operand_b = '0;
		req_ch.exponent = '0;
		req_ch.raw_value = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		error_count = 0;
		calm = 1'b0;
		hold_go = 1'b0;
		req_fire = 1'b0;
		send_gap = 0;
		stall_left = 0;
		hold_left = 0;
		modulus_shadow = RESET_MODULUS;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset modulus.
		pending_requests.push_back(make_request(K_REDUCE, 0, 0, 0, EXP_MOST_NEG));
		pending_requests.push_back(make_request(K_REDUCE, 0, 0, 0, EXP_MOST_POS));
		pending_requests.push_back(make_request(K_REDUCE, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
		pending_requests.push_back(make_request(K_REDUCE, 5, 5, 0, 64'd0 - 64'd1000000007));
		pending_requests.push_back(make_request(K_ADD, VALUE_MAX, VALUE_MAX, 0, 0));
		pending_requests.push_back(make_request(K_ADD, 62'd1000000006, 62'd1, 0, 0));
		pending_requests.push_back(make_request(K_SUB, 62'd3, 62'd10, 0, 0));
		pending_requests.push_back(make_request(K_SUB, 62'd1000000007, 62'd0, 0, 0));
		pending_requests.push_back(make_request(K_MUL, VALUE_MAX, 62'd1000000006, 0, 0));
		pending_requests.push_back(make_request(K_DIV, 62'd12, 62'd0, 0, 0));
		pending_requests.push_back(make_request(K_DIV, 62'd12, 62'd4, 0, 0));
		pending_requests.push_back(make_request(K_POW, 62'd0, 62'd7, 64'd0, 0));
		pending_requests.push_back(make_request(K_POW, 62'd3, 62'd7, EXP_MOST_NEG, 0));
		pending_requests.push_back(make_request(K_POW, 62'd3, 62'd7, EXP_MOST_POS, 0));
		pending_requests.push_back(make_request(K_POW, 62'd2, 62'd7, 64'd0 - 64'd3, 0));
		pending_requests.push_back(make_request(K_NEG, 62'd0, 62'd1, 0, 0));
		pending_requests.push_back(make_request(K_NEG, 62'd42, 62'd1, 0, 0));
		pending_requests.push_back(make_request(K_INV, 62'd0, 62'd0, 0, 0));
		pending_requests.push_back(make_request(K_INV, 62'd1, VALUE_MAX, 0, 0));
		pending_requests.push_back(make_request(K_INV, VALUE_MAX, 62'd7, 0, 0));
		add_random(25);
		drain();

		write_modulus(62'd2);
		pending_requests.push_back(make_request(K_INV, 62'd0, 62'd1, 0, 0));
		pending_requests.push_back(make_request(K_DIV, 62'd1, 62'd0, 0, 0));
		add_random(8);
		drain();

		// Register values below two act as two.
		write_modulus(62'd0);
		add_random(5);
		drain();
		write_modulus(62'd1);
		add_random(5);
		drain();

		write_modulus(BIG_PRIME);
		add_random(20);
		drain();

		// Long receiver hold-off while cheap requests keep coming, so the queue fills.
		write_modulus(62'd97);
		hold_go = 1'b1;
		for (int i = 0; i < 10; i++)
			pending_requests.push_back(make_request(K_ADD, pick_operand(97),
				pick_operand(97), 0, 0));
		add_random(15);
		drain();

		calm = 1'b1;
		write_modulus(VALUE_MAX);
		add_random(12);
		drain();

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end
endmodule

/* modular_arithmetic_unit_top.f */
src/mau_pkg.sv
src/mau_if.sv
src/mau_front.sv
src/mau_back.sv
src/modular_arithmetic_unit_top.sv
bench/tb_top.sv
